@@ src/l4fx_pkg.sv @@
`default_nettype none

package l4fx_pkg;

   // frame length counter width
   localparam int LENGTH_BITS = 16;
   // compare width: a 16-bit length field added to a header offset
   localparam int CMP_BITS = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [LENGTH_BITS-1:0] len_type;
   typedef logic [CMP_BITS-1:0]    cmp_type;

   localparam len_type LEN_MAX = {LENGTH_BITS{1'b1}};

   // link types
   localparam logic [31:0] LINK_ETHERNET = 32'd1;
   localparam logic [31:0] LINK_COOKED   = 32'd113;
   localparam logic [31:0] LINK_RAW_A    = 32'd12;
   localparam logic [31:0] LINK_RAW_B    = 32'd101;

   // ether types
   localparam logic [15:0] ETH_VLAN = 16'h8100;
   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;

   localparam logic [3:0] IP_V4 = 4'd4;
   localparam logic [3:0] IP_V6 = 4'd6;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   localparam logic [4:0] NS_RAW     = 5'd0;
   localparam logic [4:0] NS_ETH     = 5'd14;
   localparam logic [4:0] NS_COOKED  = 5'd16;
   localparam logic [4:0] NS_ETH_TAG = 5'd18;

   localparam logic [6:0] IPV6_HDR_BYTES = 7'd40;

   // per-frame digest handed from front to back
   typedef struct packed {
      len_type      len;
      logic         fail;
      logic [7:0]   first_byte;
      logic [15:0]  type_12;
      logic [15:0]  type_14;
      logic [15:0]  type_16;
      logic [7:0]   ver_byte;
      logic [7:0]   proto;
      logic [127:0] src;
      logic [127:0] dst;
      logic [31:0]  ports;
      logic [63:0]  seq_ack;
      logic [3:0]   data_off;
      logic [7:0]   flags;
   } summary_type;

   typedef struct packed {
      logic         ok;
      logic [2:0]   ip_ver;
      logic [7:0]   proto_number;
      logic [63:0]  source_high;
      logic [63:0]  source_low;
      logic [63:0]  dest_high;
      logic [63:0]  dest_low;
      logic [31:0]  port_pair;
      logic [63:0]  seq_and_ack;
      logic [7:0]   flag_bits;
      logic [7:0]   payload_start;
      logic [15:0]  payload_bytes;
   } result_type;

   typedef struct packed {
      logic                   valid;
      logic                   full;
      logic [QCOUNT_BITS-1:0] count;
   } queue_status_type;

   function automatic logic is_ip_type(input logic [15:0] t);
      return (t == ETH_IPV4) || (t == ETH_IPV6);
   endfunction

   // offset of the network header, from what is known of the frame
   function automatic logic [4:0] network_start(input logic [31:0] link,
                                                input logic [7:0]  first,
                                                input logic [15:0] t12);
      logic [4:0] ns;
      ns = NS_RAW;
      if (link == LINK_ETHERNET) begin
         ns = (t12 == ETH_VLAN) ? NS_ETH_TAG : NS_ETH;
      end else if (link == LINK_COOKED) begin
         ns = NS_COOKED;
      end else if (link == LINK_RAW_A || link == LINK_RAW_B) begin
         ns = NS_RAW;
      end else if (first[7:4] == IP_V4 || first[7:4] == IP_V6) begin
         ns = NS_RAW;
      end else begin
         ns = NS_ETH;
      end
      return ns;
   endfunction

endpackage

`default_nettype wire

@@ src/l4fx_front.sv @@
`default_nettype none

module l4fx_front import l4fx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] link_type,
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_end_of_frame,
   output logic             req_stall,
   input  wire logic        queue_full,
   output logic             push,
   output summary_type      summary
);

   len_type      idx_ff, idx_in;
   logic         fail_ff, fail_in;
   logic [7:0]   first_ff, first_in;
   logic [15:0]  t12_ff, t12_in, t14_ff, t14_in, t16_ff, t16_in;
   logic         ip_seen_ff, ip_seen_in;
   logic [7:0]   verb_ff, verb_in;
   logic [7:0]   proto_ff, proto_in;
   logic [127:0] src_ff, src_in, dst_ff, dst_in;
   logic [31:0]  ports_ff, ports_in;
   logic [63:0]  seqack_ff, seqack_in;
   logic [3:0]   doff_ff, doff_in;
   logic [7:0]   flags_ff, flags_in;

   logic         fire;
   logic [7:0]   b;
   len_type      ns, rel, ts, relt, len_now;
   logic [6:0]   ts_small;
   logic         at_ns, past_ns, v4, v6, in_tp;
   summary_type  cap;

   always_comb begin
      fire      = req_valid && !queue_full;
      req_stall = queue_full;
      b         = req_frame_byte;

      first_in = (idx_ff == '0) ? b : first_ff;
      ns       = len_type'(network_start(link_type, first_in, t12_ff));
      at_ns    = (idx_ff == ns);
      past_ns  = ip_seen_ff && (idx_ff > ns);
      rel      = idx_ff - ns;
      v4       = (verb_ff[7:4] == IP_V4);
      v6       = (verb_ff[7:4] == IP_V6);

      ts_small = {2'b00, ns[4:0]} + (v4 ? {1'b0, verb_ff[3:0], 2'b00} : IPV6_HDR_BYTES);
      ts       = len_type'(ts_small);
      in_tp    = past_ns && (idx_ff >= ts);
      relt     = idx_ff - ts;

      t12_in = (idx_ff == len_type'(12) || idx_ff == len_type'(13)) ?
               {t12_ff[7:0], b} : t12_ff;
      t14_in = (idx_ff == len_type'(14) || idx_ff == len_type'(15)) ?
               {t14_ff[7:0], b} : t14_ff;
      t16_in = (idx_ff == len_type'(16) || idx_ff == len_type'(17)) ?
               {t16_ff[7:0], b} : t16_ff;

      verb_in    = at_ns ? b : verb_ff;
      ip_seen_in = ip_seen_ff || at_ns;

      proto_in = (past_ns && ((v4 && rel == len_type'(9)) || (v6 && rel == len_type'(6)))) ?
                 b : proto_ff;
      src_in = (past_ns &&
                ((v4 && rel >= len_type'(12) && rel <= len_type'(15)) ||
                 (v6 && rel >= len_type'(8)  && rel <= len_type'(23)))) ?
               {src_ff[119:0], b} : src_ff;
      dst_in = (past_ns &&
                ((v4 && rel >= len_type'(16) && rel <= len_type'(19)) ||
                 (v6 && rel >= len_type'(24) && rel <= len_type'(39)))) ?
               {dst_ff[119:0], b} : dst_ff;

      ports_in  = (in_tp && relt <= len_type'(3)) ? {ports_ff[23:0], b} : ports_ff;
      // place each byte in its own lane: the UDP length stays in the top
      // bits even when the frame ends right after the UDP header
      seqack_in = seqack_ff;
      for (int k = 0; k < 8; k++) begin
         if (in_tp && relt == len_type'(k + 4)) begin
            seqack_in[63 - 8*k -: 8] = b;
         end
      end
      doff_in   = (in_tp && relt == len_type'(12)) ? b[7:4] : doff_ff;
      flags_in  = (in_tp && relt == len_type'(13)) ? b : flags_ff;

      // saturate the count; a byte past the limit marks the frame failed
      len_now = (idx_ff == LEN_MAX) ? LEN_MAX : idx_ff + len_type'(1);
      fail_in = fail_ff || (idx_ff == LEN_MAX);
      idx_in  = len_now;

      cap.len        = len_now;
      cap.fail       = fail_in;
      cap.first_byte = first_in;
      cap.type_12    = t12_in;
      cap.type_14    = t14_in;
      cap.type_16    = t16_in;
      cap.ver_byte   = verb_in;
      cap.proto      = proto_in;
      cap.src        = src_in;
      cap.dst        = dst_in;
      cap.ports      = ports_in;
      cap.seq_ack    = seqack_in;
      cap.data_off   = doff_in;
      cap.flags      = flags_in;

      summary = cap;
      push    = fire && req_end_of_frame;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && req_end_of_frame)) begin
         idx_ff     <= '0;
         fail_ff    <= 1'b0;
         first_ff   <= '0;
         t12_ff     <= '0;
         t14_ff     <= '0;
         t16_ff     <= '0;
         ip_seen_ff <= 1'b0;
         verb_ff    <= '0;
         proto_ff   <= '0;
         src_ff     <= '0;
         dst_ff     <= '0;
         ports_ff   <= '0;
         seqack_ff  <= '0;
         doff_ff    <= '0;
         flags_ff   <= '0;
      end else if (fire) begin
         idx_ff     <= idx_in;
         fail_ff    <= fail_in;
         first_ff   <= first_in;
         t12_ff     <= t12_in;
         t14_ff     <= t14_in;
         t16_ff     <= t16_in;
         ip_seen_ff <= ip_seen_in;
         verb_ff    <= verb_in;
         proto_ff   <= proto_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         ports_ff   <= ports_in;
         seqack_ff  <= seqack_in;
         doff_ff    <= doff_in;
         flags_ff   <= flags_in;
      end
   end

endmodule

`default_nettype wire

@@ src/l4fx_queue.sv @@
`default_nettype none

module l4fx_queue import l4fx_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire summary_type push_data,
   input  wire logic  pop,
   output summary_type head,
   output queue_status_type status
);

   summary_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;

   function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
   endfunction

   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = count_ff + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);
      head     = mem_ff[rd_ff];
      status.valid = (count_ff != '0);
      status.full  = (count_ff == QCOUNT_BITS'(QUEUE_DEPTH));
      status.count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/l4fx_back.sv @@
`default_nettype none

module l4fx_back import l4fx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] link_type,
   input  wire summary_type head,
   input  wire logic        head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output result_type       result
);

   result_type out_ff, out_in;
   logic       valid_ff, valid_in;

   always_comb begin
      logic        good;
      logic [4:0]  ns;
      logic [15:0] t;
      cmp_type     len, ns17, ts, ihl4, th, ulen;
      logic [3:0]  ver;
      result_type  r;

      r    = '0;
      good = !head.fail;
      len  = cmp_type'(head.len);
      ns   = network_start(link_type, head.first_byte, head.type_12);
      t    = head.type_12;

      if (len < cmp_type'(14)) good = 1'b0;
      if (link_type == LINK_ETHERNET) begin
         if (head.type_12 == ETH_VLAN) begin
            if (len < cmp_type'(18)) good = 1'b0;
            t = head.type_16;
         end
         if (!is_ip_type(t)) good = 1'b0;
      end else if (link_type == LINK_COOKED) begin
         if (len < cmp_type'(16)) good = 1'b0;
         if (!is_ip_type(head.type_14)) good = 1'b0;
      end else if (link_type == LINK_RAW_A || link_type == LINK_RAW_B) begin
         good = good;
      end else if (ns != NS_RAW && !is_ip_type(head.type_12)) begin
         good = 1'b0;
      end

      ns17 = cmp_type'(ns);
      if (ns17 >= len) good = 1'b0;
      ver  = head.ver_byte[7:4];
      ihl4 = cmp_type'({head.ver_byte[3:0], 2'b00});
      ts   = '0;
      if (ver == IP_V4) begin
         if (ns17 + cmp_type'(20) > len || ihl4 < cmp_type'(20) || ns17 + ihl4 > len)
            good = 1'b0;
         ts = ns17 + ihl4;
         r.source_high = {head.src[31:0], 32'h0};
         r.dest_high   = {head.dst[31:0], 32'h0};
      end else if (ver == IP_V6) begin
         if (ns17 + cmp_type'(40) > len) good = 1'b0;
         ts = ns17 + cmp_type'(40);
         r.source_high = head.src[127:64];
         r.source_low  = head.src[63:0];
         r.dest_high   = head.dst[127:64];
         r.dest_low    = head.dst[63:0];
      end else begin
         good = 1'b0;
      end
      r.ip_ver       = ver[2:0];
      r.proto_number = head.proto;

      ulen = cmp_type'(head.seq_ack[63:48]);
      th   = cmp_type'({head.data_off, 2'b00});
      if (head.proto == PROTO_UDP) begin
         if (ts + cmp_type'(8) > len) good = 1'b0;
         r.port_pair = head.ports;
         if (ulen < cmp_type'(8) || ts + ulen > len)
            r.payload_bytes = 16'(len - ts - cmp_type'(8));
         else
            r.payload_bytes = 16'(ulen - cmp_type'(8));
         r.payload_start = 8'(ts + cmp_type'(8));
      end else if (head.proto == PROTO_TCP) begin
         if (ts + cmp_type'(20) > len) good = 1'b0;
         if (th < cmp_type'(20) || ts + th > len) good = 1'b0;
         r.port_pair     = head.ports;
         r.seq_and_ack   = head.seq_ack;
         r.flag_bits     = head.flags;
         r.payload_start = 8'(ts + th);
         r.payload_bytes = 16'(len - ts - th);
      end else begin
         good = 1'b0;
      end

      r.ok = 1'b1;
      if (!good) r = '0;

      pop      = head_valid && (!valid_ff || !rsp_stall);
      out_in   = pop ? r : out_ff;
      valid_in = pop || (valid_ff && rsp_stall);
      rsp_valid = valid_ff;
      result    = out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

@@ src/l4_flow_header_extractor_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  frame_byte, end_of_frame
// rsp       out        rsp_valid/rsp_stall  ok .. payload_bytes
// csr       in         csr_write_enable     csr_write_data (link type)
//
// One byte is taken every cycle while req_stall is low; one result leaves
// per frame. The final byte's digest is written to the digest queue; the back
// stage moves it to the output register unless a stalled result is held.
// Frames of a single byte sustain one result per cycle while rsp_stall is low.
// Reset is synchronous and clears the frame counter, the queue and the
// output valid flag; the link type returns to Ethernet.
// The two-entry digest queue lets a stalled result side hold while bytes
// keep arriving; req_stall rises only when that queue is full.

module l4_flow_header_extractor_unit import l4fx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_end_of_frame,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_ok,
   output logic [2:0]       rsp_ip_ver,
   output logic [7:0]       rsp_proto_number,
   output logic [63:0]      rsp_source_high,
   output logic [63:0]      rsp_source_low,
   output logic [63:0]      rsp_dest_high,
   output logic [63:0]      rsp_dest_low,
   output logic [31:0]      rsp_port_pair,
   output logic [63:0]      rsp_seq_and_ack,
   output logic [7:0]       rsp_flag_bits,
   output logic [7:0]       rsp_payload_start,
   output logic [15:0]      rsp_payload_bytes
);

   logic [31:0]      link_ff, link_in;
   logic             push, pop;
   summary_type      digest, head;
   queue_status_type qstat;
   result_type       result;

   // hold the link type until the next write
   always_comb begin
      link_in = csr_write_enable ? csr_write_data : link_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_ETHERNET;
      end else begin
         link_ff <= link_in;
      end
   end

   // front: follow byte offsets and capture header fields as they pass
   l4fx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .link_type        (link_ff),
      .req_valid        (req_valid),
      .req_frame_byte   (req_frame_byte),
      .req_end_of_frame (req_end_of_frame),
      .req_stall        (req_stall),
      .queue_full       (qstat.full),
      .push             (push),
      .summary          (digest)
   );

   // queue of per-frame digests between capture and checking
   l4fx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (digest),
      .pop       (pop),
      .head      (head),
      .status    (qstat)
   );

   // back: length and type checks, then drive the output register
   l4fx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .link_type  (link_ff),
      .head       (head),
      .head_valid (qstat.valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result     (result)
   );

   assign rsp_ok            = result.ok;
   assign rsp_ip_ver        = result.ip_ver;
   assign rsp_proto_number  = result.proto_number;
   assign rsp_source_high   = result.source_high;
   assign rsp_source_low    = result.source_low;
   assign rsp_dest_high     = result.dest_high;
   assign rsp_dest_low      = result.dest_low;
   assign rsp_port_pair     = result.port_pair;
   assign rsp_seq_and_ack   = result.seq_and_ack;
   assign rsp_flag_bits     = result.flag_bits;
   assign rsp_payload_start = result.payload_start;
   assign rsp_payload_bytes = result.payload_bytes;

   // a failed frame reports every field as zero; checked on version, protocol, ports, source high and payload length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_ip_ver == '0 && rsp_proto_number == '0 &&
         rsp_port_pair == '0 && rsp_source_high == '0 && rsp_payload_bytes == '0))
      else $error("failed frame with non-zero fields");

   // a good frame carries IPv4 or IPv6
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_ip_ver == 3'd4 || rsp_ip_ver == 3'd6))
      else $error("good frame with bad version");

   // IPv4 leaves the low address words clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok && rsp_ip_ver == 3'd4) |->
         (rsp_source_low == '0 && rsp_dest_low == '0))
      else $error("IPv4 result with low address bits");

   // a taken final byte always lands in the digest queue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_frame) |=> (qstat.count != '0))
      else $error("frame digest lost");

endmodule

`default_nettype wire

@@ tb/l4_flow_header_extractor_unit_tb.sv @@
`timescale 1ns / 100ps

module l4_flow_header_extractor_unit_tb import l4fx_pkg::*; ();

   localparam int HDR_KEEP   = 92;
   localparam int IDLE_LIMIT = 5000;
   localparam int ITEM_TARGET = 1950;

   typedef enum int {E_ETH, E_VLAN, E_COOKED, E_RAW} encap_type;
   typedef enum int {M_NONE, M_SHORT, M_ONE, M_BADTYPE, M_BADVER,
                     M_ONES, M_ZEROS, M_CUT} mangle_type;

   typedef struct {
      logic [31:0] link;
      encap_type   enc;
      int          ver;
      logic [7:0]  proto;
      int          ihl;
      int          doff;
      int          ulen_mode;
      int          pay;
      mangle_type  mangle;
      bit          zero_result;
   } frame_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_frame_byte;
   logic        req_end_of_frame;
   logic        rsp_valid;
   logic        rsp_stall;
   result_type  rsp;

   l4_flow_header_extractor_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_frame_byte    (req_frame_byte),
      .req_end_of_frame  (req_end_of_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ok            (rsp.ok),
      .rsp_ip_ver        (rsp.ip_ver),
      .rsp_proto_number  (rsp.proto_number),
      .rsp_source_high   (rsp.source_high),
      .rsp_source_low    (rsp.source_low),
      .rsp_dest_high     (rsp.dest_high),
      .rsp_dest_low      (rsp.dest_low),
      .rsp_port_pair     (rsp.port_pair),
      .rsp_seq_and_ack   (rsp.seq_and_ack),
      .rsp_flag_bits     (rsp.flag_bits),
      .rsp_payload_start (rsp.payload_start),
      .rsp_payload_bytes (rsp.payload_bytes)
   );

   // Shadow of the block's frame state and link register
   logic [31:0] link_cfg;
   logic [7:0]  hdr_bytes [HDR_KEEP];
   int unsigned byte_count;
   bit          count_fail;

   result_type  flow_results_q [$];
   logic [7:0]  frame_bytes [$];
   bit          zero_expected;
   bit          calm;
   int          errors;
   int          frames_sent;
   int          bytes_sent;
   int          results_seen;
   int          links_used;
   int          idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [7:0] hdr_at(int unsigned i);
      return (i < HDR_KEEP) ? hdr_bytes[i] : 8'h00;
   endfunction

   function automatic logic [15:0] hdr_be16(int unsigned i);
      return {hdr_at(i), hdr_at(i + 1)};
   endfunction

   function automatic logic [63:0] hdr_be(int unsigned i, int unsigned n);
      logic [63:0] v;
      v = '0;
      for (int unsigned k = 0; k < n; k++) v = {v[55:0], hdr_at(i + k)};
      return v;
   endfunction

   function automatic result_type flow_parse(int unsigned len);
      result_type  r;
      int unsigned ns, ver, ts, ihl, ulen, th;
      logic [15:0] t;
      logic [7:0]  pr;
      r = '0;
      if (len < 14) return '0;
      if (link_cfg == LINK_ETHERNET) begin
         t  = hdr_be16(12);
         ns = 14;
         if (t == ETH_VLAN) begin
            if (len < 18) return '0;
            t  = hdr_be16(16);
            ns = 18;
         end
         if (t != ETH_IPV4 && t != ETH_IPV6) return '0;
      end else if (link_cfg == LINK_COOKED) begin
         if (len < 16) return '0;
         t = hdr_be16(14);
         if (t != ETH_IPV4 && t != ETH_IPV6) return '0;
         ns = 16;
      end else if (link_cfg == LINK_RAW_A || link_cfg == LINK_RAW_B) begin
         ns = 0;
      end else begin
         ver = hdr_at(0) >> 4;
         t   = hdr_be16(12);
         if (ver == IP_V4 || ver == IP_V6) ns = 0;
         else if (t == ETH_IPV4 || t == ETH_IPV6) ns = 14;
         else return '0;
      end

      if (ns >= len) return '0;
      ver = hdr_at(ns) >> 4;
      if (ver == IP_V4) begin
         ihl = (hdr_at(ns) & 8'h0F) * 4;
         if (ns + 20 > len || ihl < 20 || ns + ihl > len) return '0;
         pr            = hdr_at(ns + 9);
         r.source_high = {hdr_be(ns + 12, 4), 32'h0};
         r.dest_high   = {hdr_be(ns + 16, 4), 32'h0};
         ts            = ns + ihl;
      end else if (ver == IP_V6) begin
         if (ns + 40 > len) return '0;
         pr            = hdr_at(ns + 6);
         r.source_high = hdr_be(ns + 8, 8);
         r.source_low  = hdr_be(ns + 16, 8);
         r.dest_high   = hdr_be(ns + 24, 8);
         r.dest_low    = hdr_be(ns + 32, 8);
         ts            = ns + 40;
      end else begin
         return '0;
      end
      r.ip_ver       = ver[2:0];
      r.proto_number = pr;

      if (pr == PROTO_UDP) begin
         if (ts + 8 > len) return '0;
         r.port_pair = 32'(hdr_be(ts, 4));
         ulen        = hdr_be16(ts + 4);
         if (ulen < 8 || ts + ulen > len) r.payload_bytes = 16'(len - ts - 8);
         else r.payload_bytes = 16'(ulen - 8);
         r.payload_start = 8'(ts + 8);
      end else if (pr == PROTO_TCP) begin
         if (ts + 20 > len) return '0;
         r.port_pair   = 32'(hdr_be(ts, 4));
         r.seq_and_ack = hdr_be(ts + 4, 8);
         th            = ((hdr_at(ts + 12) >> 4) & 8'h0F) * 4;
         if (th < 20 || ts + th > len) return '0;
         r.flag_bits     = hdr_at(ts + 13);
         r.payload_start = 8'(ts + th);
         r.payload_bytes = 16'(len - (ts + th));
      end else begin
         return '0;
      end
      r.ok = 1'b1;
      return r;
   endfunction

   task automatic clear_frame_state();
      byte_count = 0;
      count_fail = 1'b0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
   endtask

   task automatic report_mismatch(string msg);
      errors++;
      $display("[%0t] %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("mismatch on %s: got %h, want %h", name, got, want));
      end
   endtask

   // --------------------------------------------------- monitor and scoreboard
   // Sample at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      result_type want;
      bit         moved;
      moved = 1'b0;
      if (reset) begin
         link_cfg = LINK_ETHERNET;
         clear_frame_state();
      end else begin
         if (csr_write_enable) link_cfg = csr_write_data;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if (byte_count < HDR_KEEP) hdr_bytes[byte_count] = req_frame_byte;
            if (byte_count >= LEN_MAX) count_fail = 1'b1;
            else byte_count++;
            if (req_end_of_frame) begin
               want = (count_fail || zero_expected) ? result_type'('0)
                                                    : flow_parse(byte_count);
               flow_results_q.push_back(want);
               clear_frame_state();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_seen++;
            if (flow_results_q.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = flow_results_q.pop_front();
               check_field("ok",            rsp.ok,            want.ok);
               check_field("ip_ver",        rsp.ip_ver,        want.ip_ver);
               check_field("proto_number",  rsp.proto_number,  want.proto_number);
               check_field("source_high",   rsp.source_high,   want.source_high);
               check_field("source_low",    rsp.source_low,    want.source_low);
               check_field("dest_high",     rsp.dest_high,     want.dest_high);
               check_field("dest_low",      rsp.dest_low,      want.dest_low);
               check_field("port_pair",     rsp.port_pair,     want.port_pair);
               check_field("seq_and_ack",   rsp.seq_and_ack,   want.seq_and_ack);
               check_field("flag_bits",     rsp.flag_bits,     want.flag_bits);
               check_field("payload_start", rsp.payload_start, want.payload_start);
               check_field("payload_bytes", rsp.payload_bytes, want.payload_bytes);
            end
         end
      end
      // Watchdog: a long run of cycles with no transaction on either side
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout after %0d idle cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------ result side
   // Stall in bursts: mostly short, now and then long, with clear runs between.
   initial begin
      int r;
      int n;
      rsp_stall = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 20);
         end else if (r < 95) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            n = $urandom_range(20, 60);
         end
         repeat (n) @(negedge clock);
      end
   end

   // ----------------------------------------------------------- frame builder
   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int net_offset(encap_type enc);
      case (enc)
         E_ETH:    return 14;
         E_VLAN:   return 18;
         E_COOKED: return 16;
         default:  return 0;
      endcase
   endfunction

   task automatic build_frame(encap_type enc, int ver, logic [7:0] proto, int ihl,
                              int doff, int ulen_mode, int pay);
      logic [15:0] et;
      int          ulen;
      frame_bytes.delete();
      et = (ver == 4) ? ETH_IPV4 : ETH_IPV6;
      case (enc)
         E_ETH: begin
            repeat (12) frame_bytes.push_back(rnd8());
         end
         E_VLAN: begin
            repeat (12) frame_bytes.push_back(rnd8());
            frame_bytes.push_back(ETH_VLAN[15:8]);
            frame_bytes.push_back(ETH_VLAN[7:0]);
            repeat (2) frame_bytes.push_back(rnd8());
         end
         E_COOKED: begin
            repeat (14) frame_bytes.push_back(rnd8());
         end
         default: ;
      endcase
      if (enc != E_RAW) begin
         frame_bytes.push_back(et[15:8]);
         frame_bytes.push_back(et[7:0]);
      end
      if (ver == 4) begin
         frame_bytes.push_back({IP_V4, 4'(ihl)});
         repeat (8) frame_bytes.push_back(rnd8());
         frame_bytes.push_back(proto);
         repeat (10) frame_bytes.push_back(rnd8());
         for (int i = 20; i < ihl * 4; i++) frame_bytes.push_back(rnd8());
      end else begin
         frame_bytes.push_back({IP_V6, 4'($urandom_range(0, 15))});
         repeat (5) frame_bytes.push_back(rnd8());
         frame_bytes.push_back(proto);
         repeat (33) frame_bytes.push_back(rnd8());
      end
      if (proto == PROTO_UDP) begin
         repeat (4) frame_bytes.push_back(rnd8());
         case (ulen_mode)
            0:       ulen = 8 + pay;
            1:       ulen = $urandom_range(0, 7);
            2:       ulen = 8 + pay + $urandom_range(1, 300);
            default: ulen = $urandom_range(0, 65535);
         endcase
         frame_bytes.push_back(8'(ulen >> 8));
         frame_bytes.push_back(8'(ulen));
         repeat (2) frame_bytes.push_back(rnd8());
      end else if (proto == PROTO_TCP) begin
         repeat (12) frame_bytes.push_back(rnd8());
         frame_bytes.push_back({4'(doff), 4'($urandom_range(0, 15))});
         repeat (7) frame_bytes.push_back(rnd8());
         for (int i = 20; i < doff * 4; i++) frame_bytes.push_back(rnd8());
      end
      repeat (pay) frame_bytes.push_back(rnd8());
   endtask

   task automatic apply_mangle(mangle_type m, encap_type enc);
      int noff;
      int toff;
      noff = net_offset(enc);
      toff = (enc == E_VLAN) ? 16 : noff - 2;
      case (m)
         M_SHORT: while (frame_bytes.size() > 13) void'(frame_bytes.pop_back());
         M_ONE:   while (frame_bytes.size() > 1) void'(frame_bytes.pop_back());
         M_BADTYPE: begin
            frame_bytes[toff]     = 8'h12;
            frame_bytes[toff + 1] = 8'h34;
         end
         M_BADVER: frame_bytes[noff] = 8'h50;
         M_ONES: begin
            frame_bytes.delete();
            repeat (60) frame_bytes.push_back(8'hFF);
         end
         M_ZEROS: begin
            frame_bytes.delete();
            repeat (60) frame_bytes.push_back(8'h00);
         end
         M_CUT: while (frame_bytes.size() > noff + 39) void'(frame_bytes.pop_back());
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------- sender side
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(logic [7:0] b, logic last, bit gaps_ok);
      int g;
      g = gaps_ok ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_frame_byte   <= b;
      req_end_of_frame <= last;
      // Hold the byte until the block takes it
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(bit gaps_ok);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1, gaps_ok);
      frames_sent++;
   endtask

   // Pause until every expected result has come, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (flow_results_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_link(logic [31:0] v);
      drain();
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      links_used++;
   endtask

   task automatic random_frame(logic [31:0] link);
      encap_type  enc;
      int         ver, ihl, doff, um, pay, r;
      logic [7:0] proto;
      if (link == LINK_ETHERNET) enc = ($urandom_range(0, 3) == 0) ? E_VLAN : E_ETH;
      else if (link == LINK_COOKED) enc = E_COOKED;
      else if (link == LINK_RAW_A || link == LINK_RAW_B) enc = E_RAW;
      else enc = $urandom_range(0, 1) ? E_RAW : E_ETH;
      if ($urandom_range(0, 9) == 0) enc = encap_type'($urandom_range(0, 3));
      ver   = $urandom_range(0, 1) ? 4 : 6;
      r     = $urandom_range(0, 99);
      proto = (r < 45) ? PROTO_TCP : (r < 90) ? PROTO_UDP : rnd8();
      ihl   = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
      doff  = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
      um    = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
      pay   = ($urandom_range(0, 19) != 0) ? $urandom_range(0, 24) : $urandom_range(100, 300);
      build_frame(enc, ver, proto, ihl, doff, um, pay);
      // Break a share of the frames: cut short, flip a byte, or pure noise
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 2))
            0: begin
               r = $urandom_range(1, frame_bytes.size());
               while (frame_bytes.size() > r) void'(frame_bytes.pop_back());
            end
            1: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = rnd8();
            default: begin
               frame_bytes.delete();
               repeat ($urandom_range(1, 60)) frame_bytes.push_back(rnd8());
            end
         endcase
      end
   endtask

   // --------------------------------------------------------------- main flow
   frame_row_type directed [] = '{
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 10, M_NONE,    1'b0},
      '{LINK_ETHERNET, E_VLAN,   4, PROTO_UDP, 5,  5,  0, 4,  M_NONE,    1'b0},
      '{LINK_ETHERNET, E_ETH,    6, PROTO_TCP, 5,  15, 0, 0,  M_NONE,    1'b0},
      '{LINK_COOKED,   E_COOKED, 6, PROTO_UDP, 5,  5,  0, 0,  M_NONE,    1'b0},
      '{LINK_RAW_A,    E_RAW,    4, PROTO_TCP, 15, 5,  0, 3,  M_NONE,    1'b0},
      '{LINK_RAW_B,    E_RAW,    6, PROTO_UDP, 5,  5,  1, 5,  M_NONE,    1'b0},
      '{LINK_RAW_B,    E_RAW,    4, PROTO_UDP, 5,  5,  2, 6,  M_NONE,    1'b0},
      '{32'h0,         E_RAW,    4, PROTO_UDP, 5,  5,  0, 2,  M_NONE,    1'b0},
      '{32'hFFFF_FFFF, E_ETH,    6, PROTO_TCP, 5,  6,  0, 7,  M_NONE,    1'b0},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 0,  M_SHORT,   1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 0,  M_ONE,     1'b1},
      '{LINK_RAW_A,    E_RAW,    4, PROTO_UDP, 5,  5,  0, 0,  M_ONE,     1'b1},
      '{LINK_RAW_A,    E_RAW,    4, PROTO_UDP, 5,  5,  0, 0,  M_SHORT,   1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 8,  M_BADTYPE, 1'b1},
      '{LINK_COOKED,   E_COOKED, 4, PROTO_UDP, 5,  5,  0, 8,  M_BADTYPE, 1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 8,  M_BADVER,  1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 4,  5,  0, 8,  M_NONE,    1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  4,  0, 8,  M_NONE,    1'b1},
      '{LINK_ETHERNET, E_ETH,    4, 8'd1,      5,  5,  0, 30, M_NONE,    1'b1},
      '{32'h0,         E_ETH,    4, PROTO_TCP, 5,  5,  0, 0,  M_ONES,    1'b1},
      '{LINK_ETHERNET, E_ETH,    6, PROTO_UDP, 5,  5,  0, 0,  M_CUT,     1'b1},
      '{LINK_ETHERNET, E_ETH,    4, PROTO_TCP, 5,  5,  0, 0,  M_ZEROS,   1'b1}
   };

   logic [31:0] phase_links [7] = '{LINK_ETHERNET, LINK_COOKED, LINK_RAW_A,
                                    LINK_RAW_B, 32'h0, 32'hFFFF_FFFF, 32'h0};

   initial begin
      int phase;
      logic [31:0] cur;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_frame_byte   = '0;
      req_end_of_frame = 1'b0;
      zero_expected    = 1'b0;
      calm             = 1'b0;
      errors           = 0;
      frames_sent      = 0;
      bytes_sent       = 0;
      results_seen     = 0;
      links_used       = 0;
      idle_cycles      = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames; the first runs on the link type left by reset
      foreach (directed[i]) begin
         if (i > 0) write_link(directed[i].link);
         build_frame(directed[i].enc, directed[i].ver, directed[i].proto, directed[i].ihl,
                     directed[i].doff, directed[i].ulen_mode, directed[i].pay);
         apply_mangle(directed[i].mangle, directed[i].enc);
         zero_expected = directed[i].zero_result;
         calm          = (i % 3 == 0);
         send_frame(1'b1);
         zero_expected = 1'b0;
      end

      // Random phases, each on its own link setting, until the byte budget is spent
      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         cur = (phase % 7 == 6) ? $urandom() : phase_links[phase % 7];
         write_link(cur);
         repeat ($urandom_range(1, 3)) begin
            if (bytes_sent < ITEM_TARGET) begin
               calm = ($urandom_range(0, 3) == 0);
               random_frame(cur);
               send_frame(1'b1);
            end
         end
         phase++;
      end

      drain();
      repeat (10) @(negedge clock);
      if (flow_results_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   flow_results_q.size()));
      end
      $display("Sent %0d frames (%0d bytes) over %0d link settings, %0d results checked",
               frames_sent, bytes_sent, links_used, results_seen);
      $display("Included malformed, truncated and noise frames on every link type");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
